// File: design/cigar_window_clip_assert.svh
// Assertion macros for the CIGAR window clipper.
`ifndef CIGAR_WINDOW_CLIP_ASSERT_SVH
`define CIGAR_WINDOW_CLIP_ASSERT_SVH

// Condition holds at every edge outside reset.
`define CWC_ASSERT_HOLDS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("cigar_window_clip: assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define CWC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cigar_window_clip: assertion failed");

// Consequent holds in the cycle after the antecedent.
`define CWC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cigar_window_clip: assertion failed");

`endif

// File: design/cwc_pkg.sv
// Shared constants, types and functions of the CIGAR window clipper.
`timescale 1ns / 1ps
`default_nettype none

package cwc_pkg;

   localparam int LEN_W     = 28;
   localparam int KIND_W    = 4;
   localparam int REG_W     = 32;
   localparam int CSR_IDX_W = 1;

   localparam int POS_BITS_DEFAULT = 32;
   localparam int LEN_BITS_DEFAULT = 28;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_START = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_END   = 1'd1;

   localparam logic [KIND_W-1:0] KIND_M  = 4'd0;
   localparam logic [KIND_W-1:0] KIND_I  = 4'd1;
   localparam logic [KIND_W-1:0] KIND_D  = 4'd2;
   localparam logic [KIND_W-1:0] KIND_EQ = 4'd7;
   localparam logic [KIND_W-1:0] KIND_X  = 4'd8;

   typedef struct packed {
      logic in_window;
      logic emitted;
      logic closed;
   } flags_type;

   typedef struct packed {
      logic              valid;
      logic [LEN_W-1:0]  length;
      logic [KIND_W-1:0] kind;
      logic              last;
      logic              marker;
   } result_type;

   function automatic logic advances(input logic [KIND_W-1:0] kind);
      advances = (kind == KIND_M) || (kind == KIND_I) || (kind == KIND_EQ) ||
                 (kind == KIND_X);
   endfunction

endpackage

`default_nettype wire

// File: design/cwc_if.sv
// Request and response channel interfaces of the CIGAR window clipper.
`timescale 1ns / 1ps
`default_nettype none

interface cwc_req_if;
   logic                       valid;
   logic                       ready;
   logic [cwc_pkg::LEN_W-1:0]  op_length;
   logic [cwc_pkg::KIND_W-1:0] op_kind;
   logic                       final_op;

   modport source (output valid, output op_length, output op_kind, output final_op,
                   input ready);
   modport sink (input valid, input op_length, input op_kind, input final_op,
                 output ready);
endinterface

interface cwc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [cwc_pkg::LEN_W-1:0]  clip_length;
   logic [cwc_pkg::KIND_W-1:0] clip_kind;
   logic                       run_last;
   logic                       marker_only;

   modport source (output valid, output clip_length, output clip_kind, output run_last,
                   output marker_only, input ready);
   modport sink (input valid, input clip_length, input clip_kind, input run_last,
                 input marker_only, output ready);
endinterface

`default_nettype wire

// File: design/cigar_window_clip.sv
// A beat accepted into the input register moves to the output register when free.
// One operation per cycle unless stalled; the clip logic is one add and compares.
// Results are held in an output register; a waiting result stalls the input
// only once the input register also holds a beat.
// Reset (synchronous, active high) clears window registers, valids, position and flags;
// the position and flags also clear after every final operation.
`timescale 1ns / 1ps
`default_nettype none
`include "cigar_window_clip_assert.svh"

module cigar_window_clip #(
   parameter int POS_BITS = cwc_pkg::POS_BITS_DEFAULT,
   parameter int LEN_BITS = cwc_pkg::LEN_BITS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   cwc_req_if.sink                             req_ch,
   cwc_rsp_if.source                           rsp_ch,
   input  wire logic                           csr_we,
   input  wire logic [cwc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [cwc_pkg::REG_W-1:0]      csr_wdata
);

   logic [cwc_pkg::REG_W-1:0]  window_start_ff;
   logic [cwc_pkg::REG_W-1:0]  window_end_ff;
   logic [POS_BITS-1:0]        pos_ff;
   logic [POS_BITS-1:0]        pos_in;
   cwc_pkg::flags_type         flags_ff;
   cwc_pkg::flags_type         flags_in;

   logic                       s1_valid_ff;
   logic [cwc_pkg::LEN_W-1:0]  s1_len_ff;
   logic [cwc_pkg::KIND_W-1:0] s1_kind_ff;
   logic                       s1_final_ff;

   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   cwc_pkg::result_type        rsp_ff;
   cwc_pkg::result_type        result;

   logic                       out_free;
   logic                       s1_fire;
   logic                       req_fire;

   // Config write
   always_ff @(posedge clock) begin
      if (reset) begin
         window_start_ff <= '0;
         window_end_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            cwc_pkg::CSR_WINDOW_START: window_start_ff <= csr_wdata;
            cwc_pkg::CSR_WINDOW_END:   window_end_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s1_fire      = s1_valid_ff && out_free;
   assign req_ch.ready = !s1_valid_ff || out_free;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_valid_in = out_free ? (s1_valid_ff && result.valid) : rsp_valid_ff;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_len_ff   <= req_ch.op_length;
         s1_kind_ff  <= req_ch.op_kind;
         s1_final_ff <= req_ch.final_op;
      end
   end

   cwc_step #(
      .POS_BITS(POS_BITS),
      .LEN_BITS(LEN_BITS)
   ) u_step (
      .pos          (pos_ff),
      .flags        (flags_ff),
      .window_start (window_start_ff),
      .window_end   (window_end_ff),
      .op_length    (s1_len_ff),
      .op_kind      (s1_kind_ff),
      .final_op     (s1_final_ff),
      .pos_in       (pos_in),
      .flags_in     (flags_in),
      .result       (result)
   );

   // Advance run state once per consumed beat
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         flags_ff <= '0;
      end else if (s1_fire) begin
         pos_ff   <= pos_in;
         flags_ff <= flags_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && result.valid) begin
         rsp_ff <= result;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.clip_length = rsp_ff.length;
   assign rsp_ch.clip_kind   = rsp_ff.kind;
   assign rsp_ch.run_last    = rsp_ff.last;
   assign rsp_ch.marker_only = rsp_ff.marker;

   `CWC_ASSERT_NEXT(a_clear_at_end, clock, reset, s1_fire && s1_final_ff, pos_ff == '0 && flags_ff == '0)
   `CWC_ASSERT_IMPLIES(a_closed_after_emit, clock, reset, flags_ff.closed, flags_ff.emitted)
   `CWC_ASSERT_HOLDS(a_ready_when_drained, clock, reset, rsp_valid_ff || req_ch.ready)

endmodule

`default_nettype wire

// File: design/cwc_step.sv
// Per-beat clipping logic: next position, next flags and the result of one operation.
`timescale 1ns / 1ps
`default_nettype none

module cwc_step #(
   parameter int POS_BITS = cwc_pkg::POS_BITS_DEFAULT,
   parameter int LEN_BITS = cwc_pkg::LEN_BITS_DEFAULT
) (
   input  wire logic [POS_BITS-1:0]         pos,
   input  wire cwc_pkg::flags_type          flags,
   input  wire logic [cwc_pkg::REG_W-1:0]   window_start,
   input  wire logic [cwc_pkg::REG_W-1:0]   window_end,
   input  wire logic [cwc_pkg::LEN_W-1:0]   op_length,
   input  wire logic [cwc_pkg::KIND_W-1:0]  op_kind,
   input  wire logic                        final_op,
   output logic [POS_BITS-1:0]              pos_in,
   output cwc_pkg::flags_type               flags_in,
   output cwc_pkg::result_type              result
);

   localparam int LW    = (LEN_BITS < cwc_pkg::LEN_W) ? LEN_BITS : cwc_pkg::LEN_W;
   localparam int CW    = (POS_BITS > cwc_pkg::REG_W) ? POS_BITS : cwc_pkg::REG_W;
   localparam int OUT_W = cwc_pkg::LEN_W;
   localparam int SUM_W = ((POS_BITS > LW) ? POS_BITS : LW) + 1;
   localparam logic [POS_BITS-1:0] POS_MAX = '1;

   logic [LW-1:0]       len;
   logic [SUM_W-1:0]    sum;
   logic                sat;
   logic [POS_BITS-1:0] pos_step;
   logic [CW-1:0]       qn;
   logic [CW-1:0]       wsx;
   logic [CW-1:0]       wex;
   logic [CW-1:0]       d_start;
   logic [CW-1:0]       span;
   logic [CW-1:0]       d_end;
   logic                empty;
   logic                emit;
   logic                last;
   logic [LW-1:0]       elen;
   logic [cwc_pkg::KIND_W-1:0] ekind;

   assign len      = op_length[LW-1:0];
   assign sum      = SUM_W'(pos) + SUM_W'(len);
   assign sat      = sum > SUM_W'(POS_MAX);
   assign pos_step = cwc_pkg::advances(op_kind) ?
                     (sat ? POS_MAX : sum[POS_BITS-1:0]) : pos;
   assign qn       = CW'(pos_step);
   assign wsx      = CW'(window_start);
   assign wex      = CW'(window_end);
   assign d_start  = qn - wsx;
   assign span     = wex - wsx;
   assign d_end    = qn - wex;
   assign empty    = window_end <= window_start;

   always_comb begin
      pos_in   = pos;
      flags_in = flags;
      emit     = 1'b0;
      last     = 1'b0;
      elen     = '0;
      ekind    = op_kind;
      if (!flags.closed) begin
         if (empty) begin
            emit            = 1'b1;
            ekind           = cwc_pkg::KIND_M;
            flags_in.closed = 1'b1;
         end else begin
            pos_in = pos_step;
            if (!flags.in_window) begin
               if (qn == wsx) begin
                  flags_in.in_window = 1'b1;
               end else if (qn > wsx) begin
                  flags_in.in_window = 1'b1;
                  emit               = 1'b1;
                  elen               = d_start[LW-1:0];
                  if (qn >= wex) begin
                     elen            = span[LW-1:0];
                     flags_in.closed = 1'b1;
                  end
               end
            end else if (flags.emitted || op_kind != cwc_pkg::KIND_D) begin
               emit = 1'b1;
               elen = len;
               if (qn >= wex) begin
                  elen            = len - d_end[LW-1:0];
                  flags_in.closed = 1'b1;
               end
            end
         end
         if (emit) begin
            flags_in.emitted = 1'b1;
            last             = flags_in.closed || final_op;
         end
      end
      if (final_op) begin
         pos_in   = '0;
         flags_in = '0;
      end
   end

   always_comb begin
      result.valid  = emit;
      result.length = OUT_W'(elen);
      result.kind   = ekind;
      result.last   = last;
      result.marker = 1'b0;
      if (final_op && !emit && !flags.closed) begin
         result.valid  = 1'b1;
         result.length = '0;
         result.kind   = cwc_pkg::KIND_M;
         result.last   = 1'b1;
         result.marker = 1'b1;
      end
   end

endmodule

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for cigar_window_clip: random and directed CIGAR op streams.
`timescale 1ns / 1ps

module tb;

   localparam logic [cwc_pkg::KIND_W-1:0] KIND_N   = 4'd3;
   localparam logic [cwc_pkg::KIND_W-1:0] KIND_S   = 4'd4;
   localparam logic [cwc_pkg::KIND_W-1:0] KIND_H   = 4'd5;
   localparam logic [cwc_pkg::KIND_W-1:0] KIND_P   = 4'd6;
   localparam logic [cwc_pkg::KIND_W-1:0] KIND_RSV = 4'd9;
   localparam logic [cwc_pkg::KIND_W-1:0] KIND_TOP = 4'd15;

   localparam logic [cwc_pkg::REG_W-1:0] POS_TOP = 32'hFFFF_FFFF;
   localparam logic [cwc_pkg::LEN_W-1:0] LEN_TOP = '1;

   localparam int unsigned ITEM_TARGET = 1800;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned HOLD_CYCLES = 60;
   localparam int unsigned SETTLE      = 6;

   typedef struct packed {
      logic [cwc_pkg::LEN_W-1:0]  length;
      logic [cwc_pkg::KIND_W-1:0] kind;
      logic                       run_last;
      logic                       marker;
   } clip_beat_type;

   class window_clipper;
      logic [cwc_pkg::REG_W-1:0] win_start;
      logic [cwc_pkg::REG_W-1:0] win_end;
      logic [cwc_pkg::REG_W-1:0] qpos;
      bit                        in_window;
      bit                        emitted;
      bit                        closed;
      clip_beat_type             clips_due[$];
      int unsigned               faults;

      function new();
         win_start = '0;
         win_end   = '0;
         faults    = 0;
         clear_run();
      endfunction

      function void clear_run();
         qpos      = '0;
         in_window = 1'b0;
         emitted   = 1'b0;
         closed    = 1'b0;
      endfunction

      function void write_reg(logic [cwc_pkg::CSR_IDX_W-1:0] index,
                              logic [cwc_pkg::REG_W-1:0] value);
         if (index == cwc_pkg::CSR_WINDOW_START) begin
            win_start = value;
         end else begin
            win_end = value;
         end
      endfunction

      // Advance the position, clip against the window, queue the resulting beat.
      function void note_op(logic [cwc_pkg::LEN_W-1:0] len, logic [cwc_pkg::KIND_W-1:0] kind,
                            logic fin);
         logic [cwc_pkg::REG_W:0]    sum;
         logic [cwc_pkg::REG_W-1:0]  elen;
         logic [cwc_pkg::KIND_W-1:0] ekind;
         bit                         emit;
         bit                         open;
         clip_beat_type              beat;
         emit  = 1'b0;
         elen  = '0;
         ekind = kind;
         if (!closed) begin
            if (win_end <= win_start) begin
               emit   = 1'b1;
               ekind  = cwc_pkg::KIND_M;
               closed = 1'b1;
            end else begin
               if (kind == cwc_pkg::KIND_M || kind == cwc_pkg::KIND_I ||
                   kind == cwc_pkg::KIND_EQ || kind == cwc_pkg::KIND_X) begin
                  sum  = {1'b0, qpos} + {5'd0, len};
                  qpos = sum[cwc_pkg::REG_W] ? POS_TOP : sum[cwc_pkg::REG_W-1:0];
               end
               if (!in_window) begin
                  if (qpos == win_start) begin
                     in_window = 1'b1;
                  end else if (qpos > win_start) begin
                     in_window = 1'b1;
                     emit      = 1'b1;
                     elen      = qpos - win_start;
                     if (qpos >= win_end) begin
                        elen   = win_end - win_start;
                        closed = 1'b1;
                     end
                  end
               end else if (emitted || kind != cwc_pkg::KIND_D) begin
                  emit = 1'b1;
                  elen = {4'd0, len};
                  if (qpos >= win_end) begin
                     elen   = elen - (qpos - win_end);
                     closed = 1'b1;
                  end
               end
            end
            if (emit) begin
               emitted = 1'b1;
            end
         end
         open = !closed;
         beat = '{elen[cwc_pkg::LEN_W-1:0], ekind, closed || fin, 1'b0};
         if (fin) begin
            clear_run();
            if (!emit && open) begin
               beat = '{'0, '0, 1'b1, 1'b1};
               emit = 1'b1;
            end
         end
         if (emit) begin
            clips_due = {clips_due, beat};
         end
      endfunction

      function void flag(string field, logic [cwc_pkg::REG_W-1:0] want,
                         logic [cwc_pkg::REG_W-1:0] got);
         faults++;
         $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      endfunction

      function void check_clip(clip_beat_type got);
         clip_beat_type want;
         if (clips_due.size() == 0) begin
            flag("unexpected beat, length", '0, cwc_pkg::REG_W'(got.length));
            return;
         end
         want = clips_due.pop_front();
         if (want.length != got.length) begin
            flag("clip_length", cwc_pkg::REG_W'(want.length), cwc_pkg::REG_W'(got.length));
         end
         if (want.kind != got.kind) begin
            flag("clip_kind", cwc_pkg::REG_W'(want.kind), cwc_pkg::REG_W'(got.kind));
         end
         if (want.run_last != got.run_last) begin
            flag("run_last", cwc_pkg::REG_W'(want.run_last), cwc_pkg::REG_W'(got.run_last));
         end
         if (want.marker != got.marker) begin
            flag("marker_only", cwc_pkg::REG_W'(want.marker), cwc_pkg::REG_W'(got.marker));
         end
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          csr_we;
   logic [cwc_pkg::CSR_IDX_W-1:0] csr_index;
   logic [cwc_pkg::REG_W-1:0]     csr_wdata;
   bit                            quiet;
   bit                            hold_rsp;
   int unsigned                   items_sent;
   int unsigned                   cycle_count;
   window_clipper                 clipper;

   cwc_req_if req_ch();
   cwc_rsp_if rsp_ch();

   cigar_window_clip dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("cigar_window_clip regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         clipper.check_clip(clip_beat_type'({rsp_ch.clip_length, rsp_ch.clip_kind,
                                             rsp_ch.run_last, rsp_ch.marker_only}));
      end
   end

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ch.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp     = 1'b0;
            rsp_ch.ready = 1'b1;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready = 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge clock);
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   task automatic send_op(input logic [cwc_pkg::LEN_W-1:0] len,
                          input logic [cwc_pkg::KIND_W-1:0] kind, input logic fin);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_ch.valid     = 1'b1;
      req_ch.op_length = len;
      req_ch.op_kind   = kind;
      req_ch.final_op  = fin;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      clipper.note_op(len, kind, fin);
      items_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (clipper.clips_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_window(input logic [cwc_pkg::REG_W-1:0] first,
                               input logic [cwc_pkg::REG_W-1:0] stop);
      drain();
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = cwc_pkg::CSR_WINDOW_START;
      csr_wdata = first;
      @(negedge clock);
      csr_index = cwc_pkg::CSR_WINDOW_END;
      csr_wdata = stop;
      @(negedge clock);
      csr_we = 1'b0;
      clipper.write_reg(cwc_pkg::CSR_WINDOW_START, first);
      clipper.write_reg(cwc_pkg::CSR_WINDOW_END, stop);
   endtask

   task automatic random_window(input bit wide);
      logic [cwc_pkg::REG_W-1:0] first;
      logic [cwc_pkg::REG_W-1:0] stop;
      if (!wide) begin
         first = $urandom_range(0, 40);
         case ($urandom_range(0, 9))
            0: stop = first;
            1: stop = $urandom_range(0, first);
            default: stop = first + $urandom_range(1, 60);
         endcase
      end else begin
         first = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 32'h0FFF_FFFF)
                                             : POS_TOP - $urandom_range(0, 32'h3FFF_FFFF);
         stop  = ($urandom_range(0, 4) == 0) ? POS_TOP
                                             : first + $urandom_range(0, POS_TOP - first);
      end
      write_window(first, stop);
   endtask

   task automatic random_cigar(input bit wide);
      int unsigned                count;
      bit                         noisy;
      logic [cwc_pkg::KIND_W-1:0] kind;
      logic [cwc_pkg::LEN_W-1:0]  len;
      logic                       fin;
      count = wide ? $urandom_range(10, 24) : $urandom_range(1, 12);
      noisy = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < count; i++) begin
         fin = (i == count - 1);
         if (noisy) begin
            kind = cwc_pkg::KIND_W'($urandom_range(0, 15));
            if ($urandom_range(0, 5) == 0) fin = 1'b1;
         end else if ((i == 0 || fin) && $urandom_range(0, 3) == 0) begin
            kind = $urandom_range(0, 1) ? KIND_S : KIND_H;
         end else begin
            case ($urandom_range(0, 9))
               0: kind = cwc_pkg::KIND_I;
               1: kind = cwc_pkg::KIND_D;
               2: kind = cwc_pkg::KIND_EQ;
               3: kind = cwc_pkg::KIND_X;
               4: kind = KIND_N;
               default: kind = cwc_pkg::KIND_M;
            endcase
         end
         if (wide) begin
            len = $urandom_range(0, 1) ? LEN_TOP : cwc_pkg::LEN_W'($urandom);
         end else begin
            len = ($urandom_range(0, 19) == 0) ? cwc_pkg::LEN_W'($urandom)
                                               : cwc_pkg::LEN_W'($urandom_range(0, 12));
         end
         send_op(len, kind, fin);
      end
   endtask

   initial begin
      bit wide;
      clipper          = new();
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = cwc_pkg::CSR_WINDOW_START;
      csr_wdata        = '0;
      req_ch.valid     = 1'b0;
      req_ch.op_length = '0;
      req_ch.op_kind   = cwc_pkg::KIND_M;
      req_ch.final_op  = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty window straight out of reset
      send_op(28'd5, cwc_pkg::KIND_M, 1'b0);
      send_op(28'd3, cwc_pkg::KIND_D, 1'b1);

      write_window(32'd10, 32'd20);
      send_op(28'd3, KIND_S, 1'b0);
      send_op(28'd10, cwc_pkg::KIND_M, 1'b0);
      send_op(28'd4, cwc_pkg::KIND_D, 1'b0);
      send_op(28'd3, cwc_pkg::KIND_I, 1'b0);
      send_op(28'd7, KIND_N, 1'b0);
      send_op(28'd5, cwc_pkg::KIND_EQ, 1'b0);
      send_op(28'd4, cwc_pkg::KIND_X, 1'b0);
      send_op(28'd9, KIND_H, 1'b0);
      send_op(28'd1, KIND_P, 1'b1);
      send_op(28'd25, cwc_pkg::KIND_M, 1'b1);
      send_op(28'd12, cwc_pkg::KIND_M, 1'b0);
      send_op(LEN_TOP, KIND_TOP, 1'b1);
      send_op(28'd5, cwc_pkg::KIND_M, 1'b1);

      // reversed window
      write_window(POS_TOP, 32'd0);
      send_op(28'd0, KIND_RSV, 1'b1);

      write_window(32'd0, POS_TOP);
      send_op(28'd7, cwc_pkg::KIND_D, 1'b0);
      send_op(28'd3, cwc_pkg::KIND_D, 1'b0);
      send_op(LEN_TOP, cwc_pkg::KIND_M, 1'b1);

      // stall the result side long enough to back up the input
      write_window(32'd0, 32'd100000);
      hold_rsp = 1'b1;
      repeat (10) random_cigar(1'b0);

      while (items_sent < ITEM_TARGET) begin
         wide  = ($urandom_range(0, 2) == 0);
         quiet = (items_sent >= ITEM_TARGET * 4 / 5);
         random_window(wide);
         repeat (wide ? 4 : 10) random_cigar(wide);
      end
      drain();

      if (clipper.faults == 0 && clipper.clips_due.size() == 0) begin
         $display("cigar_window_clip regression: pass");
      end else begin
         $display("cigar_window_clip regression: fail");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+design
design/cwc_pkg.sv
design/cwc_if.sv
design/cwc_step.sv
design/cigar_window_clip.sv
test/tb.sv
